@@ rtl/power_rail_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// power rail sequencer assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef POWER_RAIL_SEQUENCER_MACROS_SVH
`define POWER_RAIL_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define PRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("power rail sequencer check failed");

// next-cycle implication, disabled while reset is high
`define PRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("power rail sequencer check failed");

`endif

@@ rtl/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// payload types and fixed codes of the power rail sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

   // input item
   typedef struct packed {
      logic [2:0] func;
      logic [1:0] rail;
      logic       pg_high;
      logic       pg_mid;
      logic [1:0] fault_source;
   } req_type;

   // result item
   typedef struct packed {
      logic       en_high;
      logic       en_mid;
      logic       en_low;
      logic       en_clock;
      logic       busy_res;
      logic       done_res;
      logic [2:0] status;
      logic [2:0] faults_read;
   } rsp_type;

   // command codes
   localparam logic [2:0] FUNC_TICK    = 3'd0;
   localparam logic [2:0] FUNC_UP      = 3'd1;
   localparam logic [2:0] FUNC_DOWN    = 3'd2;
   localparam logic [2:0] FUNC_EFUSE   = 3'd3;
   localparam logic [2:0] FUNC_DISABLE = 3'd4;
   localparam logic [2:0] FUNC_READ    = 3'd5;

   // status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_TO_HIGH  = 3'd1;
   localparam logic [2:0] STATUS_TO_MID   = 3'd2;
   localparam logic [2:0] STATUS_BAD_RAIL = 3'd3;
   localparam logic [2:0] STATUS_BUSY     = 3'd4;

   // rail codes
   localparam logic [1:0] RAIL_HIGH = 2'd0;
   localparam logic [1:0] RAIL_MID  = 2'd1;
   localparam logic [1:0] RAIL_LOW  = 2'd2;

   // fault event codes
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_HIGH = 2'd1;
   localparam logic [1:0] FAULT_MID  = 2'd2;
   localparam logic [1:0] FAULT_LOW  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_PG_TIMEOUT   = 3'd0;
   localparam logic [2:0] REG_SETTLE_LOW   = 3'd1;
   localparam logic [2:0] REG_SETTLE_OSC   = 3'd2;
   localparam logic [2:0] REG_EFUSE_DISCH  = 3'd3;
   localparam logic [2:0] REG_DOWN_GAP     = 3'd4;

   // register reset values
   localparam logic [15:0] PG_TIMEOUT_RST  = 16'd200;
   localparam logic [15:0] SETTLE_LOW_RST  = 16'd10;
   localparam logic [15:0] SETTLE_OSC_RST  = 16'd2;
   localparam logic [15:0] EFUSE_DISCH_RST = 16'd10;
   localparam logic [15:0] DOWN_GAP_RST    = 16'd1;

endpackage

`default_nettype wire

@@ rtl/power_rail_sequencer.sv @@
// ----------------------------------------------------------------------------
// power_rail_sequencer
// sequences the 5 V, 3.3 V and 1.8 V rail enables and the oscillator enable
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one item per transfer: a millisecond tick or a command,
//    always with the sampled power-good levels and a fault event.
//  - rsp_* returns exactly one result per item, in order: the enables after
//    the item, busy, done, status and the fault bits on a read.
//  - csr_* writes the five delay registers; write only while idle.
//  - Result path: the input register holds the item, then the sequencer
//    update is written into the result register.
//  - Throughput: one item per cycle while the result is not stalled; the
//    whole state update for an item, including up to two chained zero-length
//    delays, is one pass of logic between the input and result registers.
//  - Reset: rails and oscillator off, sequencer idle, fault bits cleared,
//    registers back to their defaults, both channel registers empty.
//  - A stalled result holds; the input register still takes one more item
//    and then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module power_rail_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   // input channel
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire prs_pkg::req_type  req_data,
   // result channel
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      prs_pkg::rsp_type  rsp_data,
   // register write port
   input  wire logic              csr_wen,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   // enable vector bit positions
   localparam int EN_HIGH = 0;
   localparam int EN_MID  = 1;
   localparam int EN_LOW  = 2;
   localparam int EN_CLK  = 3;

   typedef enum logic [3:0] {
      IDLE,
      UP_HIGH,
      UP_MID,
      UP_LOW,
      UP_OSC,
      DN_LOW,
      DN_GAP,
      EF_DIS,
      EF_PG
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] wc;
      logic [3:0]  en;
      logic [1:0]  target;
      logic        done;
   } seq_type;

   // registers
   logic              req_vld_ff;
   prs_pkg::req_type  req_ff;
   logic              rsp_vld_ff;
   prs_pkg::rsp_type  rsp_ff;
   prs_pkg::rsp_type  rsp_in;
   phase_type         phase_ff;
   phase_type         phase_in;
   logic [15:0]       wait_ff;
   logic [15:0]       wait_in;
   logic [3:0]        en_ff;
   logic [3:0]        en_in;
   logic [2:0]        fault_ff;
   logic [2:0]        fault_in;
   logic [1:0]        target_ff;
   logic [1:0]        target_in;
   logic [15:0]       pg_timeout_ff;
   logic [15:0]       settle_low_ff;
   logic [15:0]       settle_osc_ff;
   logic [15:0]       efuse_disch_ff;
   logic [15:0]       down_gap_ff;

   logic              req_accept;
   logic              out_move;

   // handshake
   assign out_move   = req_vld_ff & (~rsp_vld_ff | ~rsp_stall);
   assign req_stall  = req_vld_ff & ~out_move;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   // delay length of a timed phase
   function automatic logic [16:0] delay_of(phase_type ph);
      logic [16:0] r;
      case (ph)
         UP_LOW:  r = {1'b1, settle_low_ff};
         UP_OSC:  r = {1'b1, settle_osc_ff};
         DN_LOW:  r = {1'b1, settle_low_ff};
         DN_GAP:  r = {1'b1, down_gap_ff};
         EF_DIS:  r = {1'b1, efuse_disch_ff};
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // enable bit of the rail under efuse reset
   function automatic logic [3:0] rail_mask(logic [1:0] rail);
      logic [3:0] m;
      m = '0;
      if (rail == prs_pkg::RAIL_HIGH) begin
         m[EN_HIGH] = 1'b1;
      end else begin
         m[EN_MID] = 1'b1;
      end
      return m;
   endfunction

   // one expiry step of a timed phase
   function automatic seq_type settle_step(seq_type s);
      seq_type     r;
      logic [16:0] d;
      r = s;
      d = delay_of(s.phase);
      if (d[16] && (s.wc >= d[15:0])) begin
         r.wc = '0;
         case (s.phase)
            UP_LOW: begin
               r.en[EN_CLK] = 1'b1;
               r.phase      = UP_OSC;
            end
            UP_OSC: begin
               r.phase = IDLE;
               r.done  = 1'b1;
            end
            DN_LOW: begin
               r.en[EN_MID] = 1'b0;
               r.phase      = DN_GAP;
            end
            DN_GAP: begin
               r.en[EN_HIGH] = 1'b0;
               r.phase       = IDLE;
               r.done        = 1'b1;
            end
            EF_DIS: begin
               r.en    = s.en | rail_mask(s.target);
               r.phase = EF_PG;
            end
            default: begin
               r.phase = IDLE;
            end
         endcase
      end
      return r;
   endfunction

   // sequencer update for the item in the input register
   always_comb begin
      seq_type          s0;
      seq_type          s1;
      seq_type          s2;
      logic [2:0]       fb;
      logic [2:0]       status;
      logic [2:0]       fread;
      logic [15:0]      wc_inc;
      logic             pg;
      logic             busy_cmd;
      prs_pkg::req_type rq;

      rq        = req_ff;
      s0.phase  = phase_ff;
      s0.wc     = wait_ff;
      s0.en     = en_ff;
      s0.target = target_ff;
      s0.done   = 1'b0;
      status    = prs_pkg::STATUS_OK;
      fread     = '0;
      wc_inc    = wait_ff + 16'd1;
      pg        = 1'b0;

      // latch the fault event first
      fb = fault_ff;
      case (rq.fault_source)
         prs_pkg::FAULT_HIGH: fb[0] = 1'b1;
         prs_pkg::FAULT_MID:  fb[1] = 1'b1;
         prs_pkg::FAULT_LOW:  fb[2] = 1'b1;
         default:             fb    = fault_ff;
      endcase

      busy_cmd = (rq.func inside {[prs_pkg::FUNC_UP:prs_pkg::FUNC_DISABLE]})
                 && (phase_ff != IDLE);

      if (busy_cmd) begin
         s0.done = 1'b1;
         status  = prs_pkg::STATUS_BUSY;
      end else begin
         case (rq.func)
            prs_pkg::FUNC_TICK: begin
               if (phase_ff == IDLE) begin
                  s0.phase = IDLE;
               end else if (delay_of(phase_ff) != 17'd0) begin
                  // timed phase: count, expiry handled below
                  s0.wc = wc_inc;
               end else begin
                  case (phase_ff)
                     UP_HIGH: pg = rq.pg_high;
                     UP_MID:  pg = rq.pg_mid;
                     default: pg = (target_ff == prs_pkg::RAIL_HIGH) ?
                                   rq.pg_high : rq.pg_mid;
                  endcase
                  if (!(phase_ff inside {UP_HIGH, UP_MID, EF_PG})) begin
                     s0.phase = IDLE;
                     s0.wc    = '0;
                  end else if (pg) begin
                     s0.wc = '0;
                     case (phase_ff)
                        UP_HIGH: begin
                           s0.en[EN_MID] = 1'b1;
                           s0.phase      = UP_MID;
                        end
                        UP_MID: begin
                           s0.en[EN_LOW] = 1'b1;
                           s0.phase      = UP_LOW;
                        end
                        default: begin
                           s0.phase = IDLE;
                           s0.done  = 1'b1;
                        end
                     endcase
                  end else begin
                     s0.wc = wc_inc;
                     // power-good timeout
                     if (wc_inc >= pg_timeout_ff) begin
                        s0.wc    = '0;
                        s0.phase = IDLE;
                        s0.done  = 1'b1;
                        case (phase_ff)
                           UP_HIGH: begin
                              s0.en[EN_HIGH] = 1'b0;
                              status         = prs_pkg::STATUS_TO_HIGH;
                           end
                           UP_MID: begin
                              s0.en[EN_HIGH] = 1'b0;
                              s0.en[EN_MID]  = 1'b0;
                              status         = prs_pkg::STATUS_TO_MID;
                           end
                           default: begin
                              s0.en  = en_ff & ~rail_mask(target_ff);
                              status = (target_ff == prs_pkg::RAIL_HIGH) ?
                                       prs_pkg::STATUS_TO_HIGH :
                                       prs_pkg::STATUS_TO_MID;
                           end
                        endcase
                     end
                  end
               end
            end
            prs_pkg::FUNC_UP: begin
               s0.en[EN_HIGH] = 1'b1;
               s0.phase       = UP_HIGH;
               s0.wc          = '0;
            end
            prs_pkg::FUNC_DOWN: begin
               s0.en[EN_CLK] = 1'b0;
               s0.en[EN_LOW] = 1'b0;
               s0.phase      = DN_LOW;
               s0.wc         = '0;
            end
            prs_pkg::FUNC_EFUSE: begin
               if (rq.rail[1]) begin
                  s0.done = 1'b1;
                  status  = prs_pkg::STATUS_BAD_RAIL;
               end else begin
                  s0.target = rq.rail;
                  s0.en     = en_ff & ~rail_mask(rq.rail);
                  s0.phase  = EF_DIS;
                  s0.wc     = '0;
               end
            end
            prs_pkg::FUNC_DISABLE: begin
               case (rq.rail)
                  prs_pkg::RAIL_HIGH: s0.en[EN_HIGH] = 1'b0;
                  prs_pkg::RAIL_MID:  s0.en[EN_MID]  = 1'b0;
                  prs_pkg::RAIL_LOW:  s0.en[EN_LOW]  = 1'b0;
                  default:            s0.en          = en_ff;
               endcase
               s0.done = 1'b1;
            end
            prs_pkg::FUNC_READ: begin
               fread   = fb;
               fb      = '0;
               s0.done = 1'b1;
            end
            default: begin
               s0.done = 1'b0;
            end
         endcase
      end

      // zero-length delays chain within the item, at most two deep
      s1 = settle_step(s0);
      s2 = settle_step(s1);

      phase_in  = s2.phase;
      wait_in   = s2.wc;
      en_in     = s2.en;
      target_in = s2.target;
      fault_in  = fb;

      rsp_in.en_high     = s2.en[EN_HIGH];
      rsp_in.en_mid      = s2.en[EN_MID];
      rsp_in.en_low      = s2.en[EN_LOW];
      rsp_in.en_clock    = s2.en[EN_CLK];
      rsp_in.busy_res    = (s2.phase != IDLE);
      rsp_in.done_res    = s2.done;
      rsp_in.status      = status;
      rsp_in.faults_read = fread;
   end

   // state, registers and channel stages
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff     <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         phase_ff       <= IDLE;
         wait_ff        <= '0;
         en_ff          <= '0;
         fault_ff       <= '0;
         target_ff      <= prs_pkg::RAIL_HIGH;
         pg_timeout_ff  <= prs_pkg::PG_TIMEOUT_RST;
         settle_low_ff  <= prs_pkg::SETTLE_LOW_RST;
         settle_osc_ff  <= prs_pkg::SETTLE_OSC_RST;
         efuse_disch_ff <= prs_pkg::EFUSE_DISCH_RST;
         down_gap_ff    <= prs_pkg::DOWN_GAP_RST;
      end else begin
         // input register
         if (req_accept) begin
            req_vld_ff <= 1'b1;
         end else if (out_move) begin
            req_vld_ff <= 1'b0;
         end
         // result register
         if (out_move) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
         // sequencer state
         if (out_move) begin
            phase_ff  <= phase_in;
            wait_ff   <= wait_in;
            en_ff     <= en_in;
            fault_ff  <= fault_in;
            target_ff <= target_in;
         end
         // register writes
         if (csr_wen) begin
            case (csr_index)
               prs_pkg::REG_PG_TIMEOUT:  pg_timeout_ff  <= csr_wdata;
               prs_pkg::REG_SETTLE_LOW:  settle_low_ff  <= csr_wdata;
               prs_pkg::REG_SETTLE_OSC:  settle_osc_ff  <= csr_wdata;
               prs_pkg::REG_EFUSE_DISCH: efuse_disch_ff <= csr_wdata;
               prs_pkg::REG_DOWN_GAP:    down_gap_ff    <= csr_wdata;
               default:                  down_gap_ff    <= down_gap_ff;
            endcase
         end
      end
      // payload stages
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (out_move) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/prs_checker.sv @@
// ----------------------------------------------------------------------------
// prs_checker
// port-level checks on the result channel of the power rail sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "power_rail_sequencer_macros.svh"

module prs_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire prs_pkg::rsp_type  rsp_data
);

   // a stalled result stays offered and unchanged
   `PRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a non-zero status only comes with a finished command
   `PRS_ASSERT_SAME(a_status_done, clock, reset, rsp_valid && (rsp_data.status != prs_pkg::STATUS_OK), rsp_data.done_res)

   // fault bits are only returned by a read, which finishes at once
   `PRS_ASSERT_SAME(a_read_done, clock, reset, rsp_valid && (rsp_data.faults_read != 3'd0), rsp_data.done_res && (rsp_data.status == prs_pkg::STATUS_OK))

   // a refused command leaves the running sequence busy
   `PRS_ASSERT_SAME(a_busy_reject, clock, reset, rsp_valid && (rsp_data.status == prs_pkg::STATUS_BUSY), rsp_data.busy_res)

   // timeouts and bad rails leave the sequencer idle
   `PRS_ASSERT_SAME(a_fail_idle, clock, reset, rsp_valid && (rsp_data.status == prs_pkg::STATUS_TO_HIGH || rsp_data.status == prs_pkg::STATUS_TO_MID || rsp_data.status == prs_pkg::STATUS_BAD_RAIL), !rsp_data.busy_res)

endmodule

bind power_rail_sequencer prs_checker u_prs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ test/power_rail_sequencer_test.sv @@
// ----------------------------------------------------------------------------
// power_rail_sequencer_test
// Drives ticks and commands into the rail sequencer and compares every result
// against a cycle-free model of the sequencing, timeout, eFuse and fault-latch
// rules. It covers the reset, zero and largest timeout settings and several
// random ones, with random gaps on the input and stalls on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module power_rail_sequencer_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 4;
   // slowest correct run: well under 1000 items, each with an occasional gap in
   // front and stalls on the result side, plus the quiet waits
   localparam int unsigned CYCLE_LIMIT = 100_000;
   localparam int RANDOM_PHASES = 4;
   localparam int ITEMS_PER_PHASE = 125;

   // codes outside the defined ranges, still legal on the wires
   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd6;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
   localparam logic [1:0] RAIL_NONE        = 2'd3;

   // enable bit positions
   localparam int ENB_HIGH  = 0;
   localparam int ENB_MID   = 1;
   localparam int ENB_LOW   = 2;
   localparam int ENB_CLOCK = 3;

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_UP_HIGH, SEQ_UP_MID, SEQ_UP_LOW, SEQ_UP_OSC,
      SEQ_DN_LOW, SEQ_DN_GAP, SEQ_EF_DIS, SEQ_EF_PG
   } seq_phase_type;

   // -------------------------------------------------------------------------
   // sequencer prediction and result checking
   // -------------------------------------------------------------------------
   class rail_scoreboard_type;
      logic [15:0]      pg_timeout, settle_low, settle_osc, efuse_disch, down_gap;
      seq_phase_type    phase;
      logic [15:0]      wait_count;
      logic [3:0]       enables;
      logic [2:0]       fault_bits;
      logic [1:0]       target;
      logic             done;
      logic [2:0]       status;
      prs_pkg::rsp_type expected_q[$];
      int errors, accepted, checked;
      int n_ok, n_timeouts, n_busy, n_bad_rail, n_fault_reads;

      function new();
         pg_timeout  = prs_pkg::PG_TIMEOUT_RST;
         settle_low  = prs_pkg::SETTLE_LOW_RST;
         settle_osc  = prs_pkg::SETTLE_OSC_RST;
         efuse_disch = prs_pkg::EFUSE_DISCH_RST;
         down_gap    = prs_pkg::DOWN_GAP_RST;
         phase       = SEQ_IDLE;
         wait_count  = '0;
         enables     = '0;
         fault_bits  = '0;
         target      = prs_pkg::RAIL_HIGH;
      endfunction

      function void set_register(logic [2:0] idx, logic [15:0] val);
         case (idx)
            prs_pkg::REG_PG_TIMEOUT:  pg_timeout  = val;
            prs_pkg::REG_SETTLE_LOW:  settle_low  = val;
            prs_pkg::REG_SETTLE_OSC:  settle_osc  = val;
            prs_pkg::REG_EFUSE_DISCH: efuse_disch = val;
            prs_pkg::REG_DOWN_GAP:    down_gap    = val;
            default: ;
         endcase
      endfunction

      function logic [3:0] rail_mask(logic [1:0] r);
         return (r == prs_pkg::RAIL_HIGH) ? (4'b1 << ENB_HIGH) : (4'b1 << ENB_MID);
      endfunction

      // timed phases and their delay
      function bit delay_of(seq_phase_type ph, output logic [15:0] d);
         case (ph)
            SEQ_UP_LOW: begin d = settle_low;  return 1'b1; end
            SEQ_UP_OSC: begin d = settle_osc;  return 1'b1; end
            SEQ_DN_LOW: begin d = settle_low;  return 1'b1; end
            SEQ_DN_GAP: begin d = down_gap;    return 1'b1; end
            SEQ_EF_DIS: begin d = efuse_disch; return 1'b1; end
            default:    begin d = '0;          return 1'b0; end
         endcase
      endfunction

      function void finish_cmd(logic [2:0] st);
         phase      = SEQ_IDLE;
         wait_count = '0;
         done       = 1'b1;
         status     = st;
         if (st == prs_pkg::STATUS_OK) n_ok++;
         else n_timeouts++;
      endfunction

      function void expire_delay();
         wait_count = '0;
         case (phase)
            SEQ_UP_LOW: begin enables[ENB_CLOCK] = 1'b1; phase = SEQ_UP_OSC; end
            SEQ_UP_OSC: finish_cmd(prs_pkg::STATUS_OK);
            SEQ_DN_LOW: begin enables[ENB_MID] = 1'b0; phase = SEQ_DN_GAP; end
            SEQ_DN_GAP: begin
               enables[ENB_HIGH] = 1'b0;
               finish_cmd(prs_pkg::STATUS_OK);
            end
            SEQ_EF_DIS: begin
               enables = enables | rail_mask(target);
               phase   = SEQ_EF_PG;
            end
            default:    phase = SEQ_IDLE;
         endcase
      endfunction

      // zero-length delays chain within one item
      function void settle_delays();
         logic [15:0] d;
         bit timed;
         timed = delay_of(phase, d);
         while (timed && wait_count >= d) begin
            expire_delay();
            timed = delay_of(phase, d);
         end
      endfunction

      function void enter_phase(seq_phase_type ph);
         phase      = ph;
         wait_count = '0;
         settle_delays();
      endfunction

      function void advance_tick(logic pgh, logic pgm);
         logic [15:0] d;
         logic pg;
         if (phase == SEQ_IDLE) return;
         if (delay_of(phase, d)) begin
            wait_count++;
            settle_delays();
            return;
         end
         case (phase)
            SEQ_UP_HIGH: pg = pgh;
            SEQ_UP_MID:  pg = pgm;
            SEQ_EF_PG:   pg = (target == prs_pkg::RAIL_HIGH) ? pgh : pgm;
            default: begin
               phase      = SEQ_IDLE;
               wait_count = '0;
               return;
            end
         endcase
         // power good moves on at once
         if (pg) begin
            if (phase == SEQ_UP_HIGH) begin
               enables[ENB_MID] = 1'b1;
               phase            = SEQ_UP_MID;
               wait_count       = '0;
            end else if (phase == SEQ_UP_MID) begin
               enables[ENB_LOW] = 1'b1;
               enter_phase(SEQ_UP_LOW);
            end else begin
               finish_cmd(prs_pkg::STATUS_OK);
            end
            return;
         end
         // power good still low: count towards the timeout
         wait_count++;
         if (wait_count < pg_timeout) return;
         if (phase == SEQ_UP_HIGH) begin
            enables[ENB_HIGH] = 1'b0;
            finish_cmd(prs_pkg::STATUS_TO_HIGH);
         end else if (phase == SEQ_UP_MID) begin
            enables[ENB_MID]  = 1'b0;
            enables[ENB_HIGH] = 1'b0;
            finish_cmd(prs_pkg::STATUS_TO_MID);
         end else begin
            enables = enables & ~rail_mask(target);
            finish_cmd((target == prs_pkg::RAIL_HIGH) ? prs_pkg::STATUS_TO_HIGH
                                                      : prs_pkg::STATUS_TO_MID);
         end
      endfunction

      // work out the result of one accepted input transfer
      function void note_request(prs_pkg::req_type r);
         prs_pkg::rsp_type exp_rsp;
         logic [2:0] fread;
         fread  = '0;
         done   = 1'b0;
         status = prs_pkg::STATUS_OK;
         accepted++;
         if (r.fault_source != prs_pkg::FAULT_NONE)
            fault_bits[r.fault_source - 2'd1] = 1'b1;

         if (r.func >= prs_pkg::FUNC_UP && r.func <= prs_pkg::FUNC_DISABLE &&
             phase != SEQ_IDLE) begin
            done   = 1'b1;
            status = prs_pkg::STATUS_BUSY;
            n_busy++;
         end else begin
            case (r.func)
               prs_pkg::FUNC_TICK: advance_tick(r.pg_high, r.pg_mid);
               prs_pkg::FUNC_UP: begin
                  enables[ENB_HIGH] = 1'b1;
                  phase             = SEQ_UP_HIGH;
                  wait_count        = '0;
               end
               prs_pkg::FUNC_DOWN: begin
                  enables[ENB_CLOCK] = 1'b0;
                  enables[ENB_LOW]   = 1'b0;
                  enter_phase(SEQ_DN_LOW);
               end
               prs_pkg::FUNC_EFUSE: begin
                  if (r.rail == prs_pkg::RAIL_LOW || r.rail == RAIL_NONE) begin
                     done   = 1'b1;
                     status = prs_pkg::STATUS_BAD_RAIL;
                     n_bad_rail++;
                  end else begin
                     target  = r.rail;
                     enables = enables & ~rail_mask(r.rail);
                     enter_phase(SEQ_EF_DIS);
                  end
               end
               prs_pkg::FUNC_DISABLE: begin
                  case (r.rail)
                     prs_pkg::RAIL_HIGH: enables[ENB_HIGH] = 1'b0;
                     prs_pkg::RAIL_MID:  enables[ENB_MID]  = 1'b0;
                     prs_pkg::RAIL_LOW:  enables[ENB_LOW]  = 1'b0;
                     default: ;
                  endcase
                  done = 1'b1;
               end
               prs_pkg::FUNC_READ: begin
                  fread      = fault_bits;
                  fault_bits = '0;
                  done       = 1'b1;
                  if (fread != '0) n_fault_reads++;
               end
               default: ;
            endcase
         end

         exp_rsp.en_high     = enables[ENB_HIGH];
         exp_rsp.en_mid      = enables[ENB_MID];
         exp_rsp.en_low      = enables[ENB_LOW];
         exp_rsp.en_clock    = enables[ENB_CLOCK];
         exp_rsp.busy_res    = (phase != SEQ_IDLE);
         exp_rsp.done_res    = done;
         exp_rsp.status      = status;
         exp_rsp.faults_read = fread;
         expected_q.push_back(exp_rsp);
      endfunction

      function void compare_field(string name, int unsigned exp_val,
                                  int unsigned act_val);
         if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_result(prs_pkg::rsp_type got);
         prs_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         compare_field("en_high",     32'(e.en_high),     32'(got.en_high));
         compare_field("en_mid",      32'(e.en_mid),      32'(got.en_mid));
         compare_field("en_low",      32'(e.en_low),      32'(got.en_low));
         compare_field("en_clock",    32'(e.en_clock),    32'(got.en_clock));
         compare_field("busy_res",    32'(e.busy_res),    32'(got.busy_res));
         compare_field("done_res",    32'(e.done_res),    32'(got.done_res));
         compare_field("status",      32'(e.status),      32'(got.status));
         compare_field("faults_read", 32'(e.faults_read), 32'(got.faults_read));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and block instance
   // -------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   prs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   prs_pkg::rsp_type rsp_data;
   logic             csr_wen = 1'b0;
   logic [2:0]       csr_index = prs_pkg::REG_PG_TIMEOUT;
   logic [15:0]      csr_wdata = '0;

   bit                  bursts_enabled = 1'b1;
   int                  stall_left = 0;
   int unsigned         cycle_count = 0;
   int                  settings_used = 1;
   rail_scoreboard_type sb;

   power_rail_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // result side back-pressure in short bursts
   always @(negedge clock) begin
      logic next_stall;
      if (stall_left > 0) begin
         stall_left--;
         next_stall = 1'b1;
      end else if (bursts_enabled && !reset && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 3);
         next_stall = 1'b1;
      end else begin
         next_stall = 1'b0;
      end
      rsp_stall <= next_stall;
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_data);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // drive tasks
   // -------------------------------------------------------------------------

   // one input transfer, with an occasional gap in front; returns at the edge
   // where it was taken
   task automatic send_item(prs_pkg::req_type item);
      @(negedge clock);
      if (bursts_enabled && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic send_cmd(logic [2:0] f, logic [1:0] rl, logic pgh, logic pgm,
                           logic [1:0] fs);
      prs_pkg::req_type item;
      item.func         = f;
      item.rail         = rl;
      item.pg_high      = pgh;
      item.pg_mid       = pgm;
      item.fault_source = fs;
      send_item(item);
   endtask

   // hold off until every expected result has come, plus the pipeline depth
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // tick with power good high until the sequencer is idle
   task automatic bring_to_rest();
      while (sb.phase != SEQ_IDLE)
         send_cmd(prs_pkg::FUNC_TICK, prs_pkg::RAIL_HIGH, 1'b1, 1'b1,
                  prs_pkg::FAULT_NONE);
      wait_quiet();
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_register(idx, val);
   endtask

   task automatic set_registers(logic [15:0] timeout, logic [15:0] s_low,
                                logic [15:0] s_osc, logic [15:0] disch,
                                logic [15:0] gap);
      bring_to_rest();
      write_csr(prs_pkg::REG_PG_TIMEOUT,  timeout);
      write_csr(prs_pkg::REG_SETTLE_LOW,  s_low);
      write_csr(prs_pkg::REG_SETTLE_OSC,  s_osc);
      write_csr(prs_pkg::REG_EFUSE_DISCH, disch);
      write_csr(prs_pkg::REG_DOWN_GAP,    gap);
      @(negedge clock);
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   // random item, shaped so that most sequences run to an end
   function automatic prs_pkg::req_type pick_item();
      prs_pkg::req_type r;
      int pick;
      r.rail         = 2'($urandom_range(prs_pkg::RAIL_HIGH, RAIL_NONE));
      r.pg_high      = ($urandom_range(0, 2) == 0);
      r.pg_mid       = ($urandom_range(0, 2) == 0);
      r.fault_source = ($urandom_range(0, 3) == 0) ?
                       2'($urandom_range(prs_pkg::FAULT_HIGH, prs_pkg::FAULT_LOW)) :
                       prs_pkg::FAULT_NONE;
      pick = $urandom_range(0, 99);
      if (sb.phase == SEQ_IDLE) begin
         if (pick < 30) r.func = prs_pkg::FUNC_UP;
         else if (pick < 42) r.func = prs_pkg::FUNC_DOWN;
         else if (pick < 57) begin
            r.func = prs_pkg::FUNC_EFUSE;
            if ($urandom_range(0, 4) != 0)
               r.rail = 2'($urandom_range(prs_pkg::RAIL_HIGH, prs_pkg::RAIL_MID));
         end
         else if (pick < 67) r.func = prs_pkg::FUNC_DISABLE;
         else if (pick < 80) r.func = prs_pkg::FUNC_READ;
         else if (pick < 85) r.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
         else r.func = prs_pkg::FUNC_TICK;
      end else begin
         if (pick < 78) r.func = prs_pkg::FUNC_TICK;
         else if (pick < 86) r.func = prs_pkg::FUNC_READ;
         else if (pick < 96)
            r.func = 3'($urandom_range(prs_pkg::FUNC_UP, prs_pkg::FUNC_DISABLE));
         else r.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      prs_pkg::req_type item;
      int counted;
      bit ignored;
      sb = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset settings: fault latch, bad rails, spare codes, busy refusals
      send_cmd(prs_pkg::FUNC_READ,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_HIGH);
      send_cmd(prs_pkg::FUNC_READ,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_MID);
      send_cmd(FUNC_SPARE_LAST,       RAIL_NONE,          1'b1, 1'b1, prs_pkg::FAULT_LOW);
      send_cmd(prs_pkg::FUNC_READ,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_EFUSE,   prs_pkg::RAIL_LOW,  1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_EFUSE,   RAIL_NONE,          1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_DISABLE, RAIL_NONE,          1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_UP,      prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_DOWN,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_READ,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_LOW);
      send_cmd(prs_pkg::FUNC_TICK,    prs_pkg::RAIL_HIGH, 1'b1, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,    prs_pkg::RAIL_HIGH, 1'b0, 1'b1, prs_pkg::FAULT_NONE);

      // zero delays: timeouts at once and fully chained steps
      set_registers('0, '0, '0, '0, '0);
      send_cmd(prs_pkg::FUNC_UP,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b0, 1'b1, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_UP,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b1, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b1, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_UP,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b1, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b0, 1'b1, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_DOWN,  prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_EFUSE, prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b0, 1'b1, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_EFUSE, prs_pkg::RAIL_MID,  1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b1, 1'b0, prs_pkg::FAULT_NONE);

      // largest timeout: power good arrives long before it runs out
      set_registers('1, '0, '0, '0, '0);
      send_cmd(prs_pkg::FUNC_UP,    prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b1, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b1, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b0, 1'b1, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_EFUSE, prs_pkg::RAIL_MID,  1'b0, 1'b0, prs_pkg::FAULT_NONE);
      send_cmd(prs_pkg::FUNC_TICK,  prs_pkg::RAIL_HIGH, 1'b0, 1'b0, prs_pkg::FAULT_NONE);

      // random sequences under random small settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_registers(16'($urandom_range(0, 12)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(0, 8)));
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            // no idling over the closing stretch
            if (p == RANDOM_PHASES - 1 && counted == ITEMS_PER_PHASE / 2)
               bursts_enabled = 1'b0;
            item    = pick_item();
            ignored = (item.func > prs_pkg::FUNC_READ) ||
                      (item.func == prs_pkg::FUNC_TICK && sb.phase == SEQ_IDLE);
            if (!ignored) counted++;
            send_item(item);
         end
      end

      wait_quiet();
      repeat (6) @(posedge clock);

      $display("%0d transfers in, %0d results checked over %0d register settings",
               sb.accepted, sb.checked, settings_used);
      $display("completed ok %0d, timeouts %0d, busy refusals %0d, bad rail %0d, %s %0d",
               sb.n_ok, sb.n_timeouts, sb.n_busy, sb.n_bad_rail, "fault reads",
               sb.n_fault_reads);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
